@@ rtl/trb_pkg.sv @@
`timescale 1ns / 1ps

package trb_pkg;

   localparam int DEF_ENTRIES_PER_RING = 64;
   localparam int DEF_RING_COUNT       = 512;

   localparam int RING_ID_W       = 9;
   localparam int ENTRY_SHIFT     = 4;
   localparam int LINK_TYPE       = 6;
   localparam int LINK_TYPE_SHIFT = 10;
   localparam int TOGGLE_FLAG     = 2;

   localparam logic [31:0] LINK_CONTROL = 32'((LINK_TYPE << LINK_TYPE_SHIFT) | TOGGLE_FLAG);

   localparam logic MODE_INIT = 1'b0;
   localparam logic MODE_PUSH = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [RING_ID_W-1:0] ring_id;
      logic [63:0]          base_address;
      logic [63:0]          entry_parameter;
      logic [31:0]          entry_status;
      logic [31:0]          entry_control;
   } req_type;

   typedef struct packed {
      logic [63:0] write_address;
      logic [63:0] write_parameter;
      logic [31:0] write_status;
      logic [31:0] write_control;
      logic        is_link_entry;
      logic        last_of_run;
   } rsp_type;

endpackage

@@ rtl/trb_ring_enqueue.sv @@
`timescale 1ns / 1ps

// Channel   Ports                      Handshake
// request   start, busy, req_item      taken at an edge with start high, busy low
// result    rsp_valid, rsp_item        one-cycle strobe, no back-pressure
//
// An init item is taken and leaves busy low. A push reads the ring's control and base
// memories, then writes back: busy stays high in the lookup state on a plain push and
// in the lookup and link states on a wrapping push, whose link entry follows the entry
// result in the next cycle. After reset, with busy high, a clearing pass sets the index
// and cycle bit of all min(RING_COUNT, 512) rings. Results leave from an output register,
// so a new item may be taken while the last result is still on the ports.
module trb_ring_enqueue #(
   parameter int ENTRIES_PER_RING = trb_pkg::DEF_ENTRIES_PER_RING,
   parameter int RING_COUNT       = trb_pkg::DEF_RING_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  trb_pkg::req_type req_item,
   output logic             rsp_valid,
   output trb_pkg::rsp_type rsp_item
);
   import trb_pkg::*;

   localparam int ID_SPAN    = 1 << RING_ID_W;
   localparam int RING_DEPTH = (RING_COUNT < ID_SPAN) ? RING_COUNT : ID_SPAN;
   localparam int RID_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int IDX_W      = $clog2(ENTRIES_PER_RING);

   typedef struct packed {
      logic             cyc;
      logic [IDX_W-1:0] idx;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_LINK
   } state_type;

   ctl_type     ctl_mem [RING_DEPTH];
   logic [63:0] base_mem [RING_DEPTH];

   state_type   state_ff;
   logic [RID_W-1:0] clr_ff;
   req_type     req_ff;
   ctl_type     ctl_rd_ff;
   logic [63:0] base_rd_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic             accept;
   logic             in_range;
   logic [RID_W-1:0] rid_acc;
   logic [RID_W-1:0] rid_ff;
   logic             init_we;
   logic             push_go;
   logic [IDX_W-1:0] idx_inc;
   logic             wrap;
   logic             ctl_we;
   logic [RID_W-1:0] ctl_wa;
   ctl_type          ctl_wd;
   logic [63:0]      entry_addr;
   logic [63:0]      link_addr;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      accept     = start && !busy;
      in_range   = (32'(req_item.ring_id) < 32'(RING_COUNT));
      rid_acc    = req_item.ring_id[RID_W-1:0];
      rid_ff     = req_ff.ring_id[RID_W-1:0];
      init_we    = accept && in_range && (req_item.mode == MODE_INIT);
      push_go    = accept && in_range && (req_item.mode == MODE_PUSH);
      idx_inc    = ctl_rd_ff.idx + IDX_W'(1);
      wrap       = (idx_inc == IDX_W'(ENTRIES_PER_RING - 1));
      entry_addr = base_rd_ff + (64'(ctl_rd_ff.idx) << ENTRY_SHIFT);
      link_addr  = base_rd_ff + (64'(idx_inc) << ENTRY_SHIFT);

      ctl_we = 1'b0;
      ctl_wa = rid_acc;
      ctl_wd = '{cyc: 1'b1, idx: '0};
      if (state_ff == ST_CLEAR) begin
         ctl_we = 1'b1;
         ctl_wa = clr_ff;
      end else if (init_we) begin
         ctl_we = 1'b1;
      end else if (state_ff == ST_LOOKUP) begin
         ctl_we = 1'b1;
         ctl_wa = rid_ff;
         if (wrap) begin
            ctl_wd = '{cyc: ~ctl_rd_ff.cyc, idx: '0};
         end else begin
            ctl_wd = '{cyc: ctl_rd_ff.cyc, idx: idx_inc};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_we) begin
         ctl_mem[ctl_wa] <= ctl_wd;
      end
      if (accept) begin
         ctl_rd_ff <= ctl_mem[rid_acc];
      end
   end

   always_ff @(posedge clock) begin
      if (init_we) begin
         base_mem[rid_acc] <= req_item.base_address;
      end
      if (accept) begin
         base_rd_ff <= base_mem[rid_acc];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               rsp_valid_ff <= 1'b0;
               clr_ff       <= clr_ff + RID_W'(1);
               if (clr_ff == RID_W'(RING_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (push_go) begin
                  req_ff   <= req_item;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               rsp_valid_ff           <= 1'b1;
               rsp_ff.write_address   <= entry_addr;
               rsp_ff.write_parameter <= req_ff.entry_parameter;
               rsp_ff.write_status    <= req_ff.entry_status;
               rsp_ff.write_control   <= req_ff.entry_control | 32'(ctl_rd_ff.cyc);
               rsp_ff.is_link_entry   <= 1'b0;
               rsp_ff.last_of_run     <= !wrap;
               state_ff               <= wrap ? ST_LINK : ST_IDLE;
            end
            ST_LINK: begin
               // link entry points back to the base with the pre-flip cycle bit
               rsp_valid_ff           <= 1'b1;
               rsp_ff.write_address   <= link_addr;
               rsp_ff.write_parameter <= base_rd_ff;
               rsp_ff.write_status    <= '0;
               rsp_ff.write_control   <= LINK_CONTROL | 32'(ctl_rd_ff.cyc);
               rsp_ff.is_link_entry   <= 1'b1;
               rsp_ff.last_of_run     <= 1'b1;
               state_ff               <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   a_link_follows_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_of_run |=> rsp_valid && rsp_item.is_link_entry)
      else $error("entry without last_of_run not followed by link entry");

   a_link_after_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.is_link_entry |->
         $past(rsp_valid) && !$past(rsp_item.last_of_run))
      else $error("link entry without preceding entry result");

   a_link_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.is_link_entry |->
         rsp_item.last_of_run && rsp_item.write_status == 32'd0
         && rsp_item.write_control[1])
      else $error("malformed link entry");

   a_accept_leads_lookup: assert property (@(posedge clock) disable iff (reset)
      push_go |=> state_ff == ST_LOOKUP && busy)
      else $error("accepted push did not reach lookup");

endmodule

@@ dv/tb_trb_ring_enqueue.sv @@
`timescale 1ns / 1ps

module tb_trb_ring_enqueue;
   import trb_pkg::*;

   localparam int RINGS        = DEF_RING_COUNT;
   localparam int SLOTS        = DEF_ENTRIES_PER_RING;
   localparam int RANDOM_ITEMS = 1530;
   localparam int CALM_ITEMS   = 200;
   localparam int HOT_RINGS    = 6;
   localparam int LIMIT        = 200000;

   class ring_writes_board;
      logic [63:0]              ring_start [RINGS];
      logic [$clog2(SLOTS)-1:0] slot_index [RINGS];
      logic                     phase_bit  [RINGS];
      rsp_type                  pending_writes [$];
      int                       mismatches;

      function new();
         foreach (slot_index[i]) begin
            ring_start[i] = '0;
            slot_index[i] = '0;
            phase_bit[i]  = 1'b1;
         end
         mismatches = 0;
      endfunction

      function string show(rsp_type w);
         return $sformatf("addr %h param %h status %h ctrl %h link %b last %b",
            w.write_address, w.write_parameter, w.write_status, w.write_control,
            w.is_link_entry, w.last_of_run);
      endfunction

      function void take_item(req_type r);
         rsp_type     w;
         logic [63:0] b;
         logic        c;
         int          nxt;
         if (int'(r.ring_id) >= RINGS) return;
         if (r.mode == MODE_INIT) begin
            ring_start[r.ring_id] = r.base_address;
            slot_index[r.ring_id] = '0;
            phase_bit[r.ring_id]  = 1'b1;
            return;
         end
         b = ring_start[r.ring_id];
         c = phase_bit[r.ring_id];
         w.write_address   = b + (64'(slot_index[r.ring_id]) << ENTRY_SHIFT);
         w.write_parameter = r.entry_parameter;
         w.write_status    = r.entry_status;
         w.write_control   = r.entry_control | {31'b0, c};
         w.is_link_entry   = 1'b0;
         nxt = int'(slot_index[r.ring_id]) + 1;
         if (nxt >= SLOTS - 1) begin
            w.last_of_run = 1'b0;
            pending_writes.push_back(w);
            // link entry in the last slot, pointing back to the base
            w.write_address   = b + (64'(nxt) << ENTRY_SHIFT);
            w.write_parameter = b;
            w.write_status    = '0;
            w.write_control   = LINK_CONTROL | {31'b0, c};
            w.is_link_entry   = 1'b1;
            w.last_of_run     = 1'b1;
            pending_writes.push_back(w);
            slot_index[r.ring_id] = '0;
            phase_bit[r.ring_id]  = ~c;
         end else begin
            w.last_of_run = 1'b1;
            pending_writes.push_back(w);
            slot_index[r.ring_id] = nxt[$clog2(SLOTS)-1:0];
         end
      endfunction

      function void match_write(rsp_type got);
         rsp_type want;
         bit      same;
         if (pending_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] write with none pending: %s", $time, show(got));
            return;
         end
         want = pending_writes.pop_front();
         same = (got.write_address === want.write_address)
             && (got.write_parameter === want.write_parameter)
             && (got.write_status === want.write_status)
             && (got.write_control === want.write_control)
             && (got.is_link_entry === want.is_link_entry)
             && (got.last_of_run === want.last_of_run);
         if (!same) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] write mismatch", $time);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   ring_writes_board board = new();
   bit               ring_ready [RINGS];
   int               cycle_count = 0;

   trb_ring_enqueue u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // note the item before checking, so the queue order holds within one edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && busy === 1'b0) board.take_item(req_item);
         if (rsp_valid === 1'b1) board.match_write(rsp_item);
      end
   end

   function automatic logic [63:0] pick_base();
      if ($urandom_range(0, 3) == 0) return {52'hF_FFFF_FFFF_FFFF, 12'($urandom)};
      return {$urandom, $urandom};
   endfunction

   function automatic req_type init_item(int id, logic [63:0] b);
      req_type r;
      r.mode            = MODE_INIT;
      r.ring_id         = id[RING_ID_W-1:0];
      r.base_address    = b;
      r.entry_parameter = {$urandom, $urandom};
      r.entry_status    = $urandom;
      r.entry_control   = $urandom;
      return r;
   endfunction

   function automatic req_type push_item(int id, logic [63:0] p, logic [31:0] s,
                                         logic [31:0] c);
      req_type r;
      r.mode            = MODE_PUSH;
      r.ring_id         = id[RING_ID_W-1:0];
      r.base_address    = {$urandom, $urandom};
      r.entry_parameter = p;
      r.entry_status    = s;
      r.entry_control   = c;
      return r;
   endfunction

   task automatic send_item(req_type r, int gap);
      if (r.mode == MODE_INIT) ring_ready[r.ring_id] = 1'b1;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic drain_writes();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending_writes.size() != 0) @(posedge clock);
   endtask

   function automatic req_type random_push(int id);
      return push_item(id, {$urandom, $urandom}, $urandom, $urandom);
   endfunction

   initial begin
      int sel;
      int id;
      int gap;
      bit mk_init;
      int hot [HOT_RINGS];

      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(init_item(0, 64'h0), 0);
      send_item(push_item(0, '0, '0, '0), 0);
      send_item(push_item(0, '1, '1, '1), 0);
      send_item(push_item(0, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEE, 32'h8000_0000), 3);
      // base near the top: the second entry address wraps past zero
      send_item(init_item(511, 64'hFFFF_FFFF_FFFF_FFF0), 0);
      send_item(push_item(511, '1, '0, 32'hFFFF_FFFE), 0);
      send_item(push_item(511, '0, '1, '0), 1);
      send_item(push_item(511, 64'h8000_0000_0000_0001, 32'h0000_0001, 32'h0000_0002), 0);
      send_item(init_item(256, '1), 0);
      send_item(push_item(256, 64'h8000_0000_0000_0000, 32'h8000_0001, 32'h0000_0003), 0);
      send_item(init_item(170, 64'h5555_5555_5555_5550), 2);
      send_item(push_item(170, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 0);
      // re-initialise a ring part way round: index and cycle start over
      send_item(init_item(0, 64'h0000_1000_0000_0000), 0);
      send_item(push_item(0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5554), 0);
      send_item(init_item(85, 64'h0), 0);
      send_item(push_item(85, 64'hFFFF_FFFF_0000_0000, 32'h0000_FFFF, 32'hFFFF_0000), 5);

      drain_writes();

      // a handful of busy rings so that wraps and cycle flips come often
      foreach (hot[i]) begin
         hot[i] = $urandom_range(0, RINGS - 1);
         send_item(init_item(hot[i], pick_base()), 0);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = $urandom_range(0, 99);
         id  = hot[$urandom_range(0, HOT_RINGS - 1)];
         if (sel < 8) id = $urandom_range(0, RINGS - 1);
         mk_init = (sel < 3) || (sel < 8 && !ring_ready[id]) || (sel >= 8 && sel < 10);
         gap = 0;
         if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
         if (n == RANDOM_ITEMS / 2) drain_writes();
         if (mk_init) send_item(init_item(id, pick_base()), gap);
         else send_item(random_push(id), gap);
      end

      drain_writes();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/trb_pkg.sv
rtl/trb_ring_enqueue.sv
dv/tb_trb_ring_enqueue.sv
